// ===== sv/kthie_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kthie_pkg
// shared types and constants of the keyed head-insert table
// ----------------------------------------------------------------------------
package kthie_pkg;

  localparam int DEPTH  = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int KEY_W  = 64;
  localparam int VAL_W  = 64;
  localparam int POS_W  = 6;
  localparam int FIDX_W = 5;
  localparam int TOT_W  = 6;
  localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [1:0] {
    CMD_ADD        = 2'd0,
    CMD_REMOVE     = 2'd1,
    CMD_LOOKUP_KEY = 2'd2,
    CMD_LOOKUP_POS = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic match;
    logic exec;
  } ctl_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// ===== sv/kthie_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kthie channel interfaces
// request and result channels of the keyed head-insert table
// ----------------------------------------------------------------------------
interface kthie_in_if;
  logic                      valid;
  logic                      ready;
  kthie_pkg::cmd_t           command;
  logic [kthie_pkg::KEY_W-1:0] key;
  logic [kthie_pkg::VAL_W-1:0] value;
  logic [kthie_pkg::POS_W-1:0] position;

  modport source (output valid, command, key, value, position, input ready);
  modport sink   (input valid, command, key, value, position, output ready);
endinterface

interface kthie_out_if;
  logic                         valid;
  logic                         ready;
  logic                         status;
  logic [kthie_pkg::FIDX_W-1:0] found_index;
  logic [kthie_pkg::VAL_W-1:0]  read_value;
  logic [kthie_pkg::TOT_W-1:0]  entry_total;
  logic                         evicted;
  logic                         dirty;

  modport source (output valid, status, found_index, read_value, entry_total, evicted, dirty,
                  input ready);
  modport sink   (input valid, status, found_index, read_value, entry_total, evicted, dirty,
                  output ready);
endinterface

// ===== sv/kthie_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kthie_ctrl
// sequencer: accept, key match, table update and result load
// ----------------------------------------------------------------------------
module kthie_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  kthie_pkg::sts_t sts,
  output kthie_pkg::ctl_t ctl
);

  kthie_pkg::state_t state_r;
  kthie_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kthie_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kthie_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = kthie_pkg::ST_MATCH;
      end
      kthie_pkg::ST_MATCH: begin
        state_nxt = kthie_pkg::ST_EXEC;
      end
      kthie_pkg::ST_EXEC: begin
        if (sts.out_free) state_nxt = kthie_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = kthie_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    ctl.capture = 1'b0;
    ctl.match   = 1'b0;
    ctl.exec    = 1'b0;
    case (state_r)
      kthie_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        ctl.capture = in_valid;
      end
      kthie_pkg::ST_MATCH: begin
        ctl.match = 1'b1;
      end
      kthie_pkg::ST_EXEC: begin
        ctl.exec = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== sv/kthie_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kthie_dpath
// shift-register key/value table, parallel key compare and result register
// ----------------------------------------------------------------------------
module kthie_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  kthie_pkg::ctl_t               ctl,
  output kthie_pkg::sts_t               sts,
  input  kthie_pkg::cmd_t               in_command,
  input  logic [kthie_pkg::KEY_W-1:0]   in_key,
  input  logic [kthie_pkg::VAL_W-1:0]   in_value,
  input  logic [kthie_pkg::POS_W-1:0]   in_position,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_status,
  output logic [kthie_pkg::FIDX_W-1:0]  out_found_index,
  output logic [kthie_pkg::VAL_W-1:0]   out_read_value,
  output logic [kthie_pkg::TOT_W-1:0]   out_entry_total,
  output logic                          out_evicted,
  output logic                          out_dirty
);

  localparam int D = kthie_pkg::DEPTH;

  // table storage
  logic [kthie_pkg::KEY_W-1:0] key_r   [D];
  logic [kthie_pkg::VAL_W-1:0] val_r   [D];
  logic [kthie_pkg::KEY_W-1:0] key_nxt [D];
  logic [kthie_pkg::VAL_W-1:0] val_nxt [D];
  logic [kthie_pkg::CNT_W-1:0] count_r;
  logic [kthie_pkg::CNT_W-1:0] count_nxt;
  logic                        dirty_r;
  logic                        dirty_nxt;

  // request
  kthie_pkg::cmd_t             req_cmd_r;
  logic [kthie_pkg::KEY_W-1:0] req_key_r;
  logic [kthie_pkg::VAL_W-1:0] req_val_r;
  logic [kthie_pkg::POS_W-1:0] req_pos_r;

  // match results
  logic [D-1:0]                match_vec;
  logic [D-1:0]                first_hit;
  logic [kthie_pkg::IDX_W-1:0] hit_idx;
  logic                        hit_r;
  logic [kthie_pkg::IDX_W-1:0] hit_idx_r;
  logic                        pos_ok_r;

  // update step
  logic [kthie_pkg::IDX_W-1:0] rd_idx;
  logic [kthie_pkg::VAL_W-1:0] rd_val;
  logic                        full;
  logic                        res_status;
  logic [kthie_pkg::IDX_W-1:0] res_idx;
  logic [kthie_pkg::VAL_W-1:0] res_val;
  logic                        res_evicted;

  // result register
  logic                         out_valid_r;
  logic                         out_status_r;
  logic [kthie_pkg::FIDX_W-1:0] out_found_index_r;
  logic [kthie_pkg::VAL_W-1:0]  out_read_value_r;
  logic [kthie_pkg::TOT_W-1:0]  out_entry_total_r;
  logic                         out_evicted_r;
  logic                         out_dirty_r;

  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      req_cmd_r <= in_command;
      req_key_r <= in_key;
      req_val_r <= in_value;
      req_pos_r <= in_position;
    end
  end

  // parallel compare over live entries, lowest index wins
  always_comb begin
    for (int i = 0; i < D; i++) begin
      match_vec[i] = (key_r[i] == req_key_r) &&
                     (kthie_pkg::CNT_W'(i) < count_r);
    end
    first_hit = match_vec & ~(match_vec - D'(1));
    hit_idx   = '0;
    for (int i = 0; i < D; i++) begin
      if (first_hit[i]) hit_idx = hit_idx | kthie_pkg::IDX_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.match) begin
      hit_r     <= |match_vec;
      hit_idx_r <= hit_idx;
      pos_ok_r  <= kthie_pkg::CMP_W'(req_pos_r) < kthie_pkg::CMP_W'(count_r);
    end
  end

  assign rd_idx = (req_cmd_r == kthie_pkg::CMD_LOOKUP_POS) ?
                  req_pos_r[kthie_pkg::IDX_W-1:0] : hit_idx_r;
  assign rd_val = val_r[rd_idx];
  assign full   = (count_r == kthie_pkg::CNT_W'(D));

  always_comb begin
    for (int i = 0; i < D; i++) begin
      key_nxt[i] = key_r[i];
      val_nxt[i] = val_r[i];
    end
    count_nxt   = count_r;
    dirty_nxt   = dirty_r;
    res_status  = 1'b0;
    res_idx     = '0;
    res_val     = '0;
    res_evicted = 1'b0;
    case (req_cmd_r)
      kthie_pkg::CMD_ADD: begin
        dirty_nxt = 1'b1;
        if (hit_r) begin
          res_idx = hit_idx_r;
          for (int i = 0; i < D; i++) begin
            if (hit_idx_r == kthie_pkg::IDX_W'(i)) val_nxt[i] = req_val_r;
          end
        end else begin
          key_nxt[0] = req_key_r;
          val_nxt[0] = req_val_r;
          for (int i = 1; i < D; i++) begin
            key_nxt[i] = key_r[i-1];
            val_nxt[i] = val_r[i-1];
          end
          res_evicted = full;
          if (!full) count_nxt = count_r + kthie_pkg::CNT_W'(1);
        end
      end
      kthie_pkg::CMD_REMOVE: begin
        if (pos_ok_r) begin
          for (int i = 0; i < D - 1; i++) begin
            if (kthie_pkg::CMP_W'(i) >= kthie_pkg::CMP_W'(req_pos_r)) begin
              key_nxt[i] = key_r[i+1];
              val_nxt[i] = val_r[i+1];
            end
          end
          count_nxt = count_r - kthie_pkg::CNT_W'(1);
          dirty_nxt = 1'b1;
          res_idx   = req_pos_r[kthie_pkg::IDX_W-1:0];
        end else begin
          res_status = 1'b1;
        end
      end
      kthie_pkg::CMD_LOOKUP_KEY: begin
        if (hit_r) begin
          res_idx = hit_idx_r;
          res_val = rd_val;
        end else begin
          res_status = 1'b1;
        end
      end
      kthie_pkg::CMD_LOOKUP_POS: begin
        if (pos_ok_r) begin
          res_idx = req_pos_r[kthie_pkg::IDX_W-1:0];
          res_val = rd_val;
        end else begin
          res_status = 1'b1;
        end
      end
      default: begin
        res_status = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      for (int i = 0; i < D; i++) begin
        key_r[i] <= key_nxt[i];
        val_r[i] <= val_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      dirty_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.exec) begin
        count_r     <= count_nxt;
        dirty_r     <= dirty_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      out_status_r      <= res_status;
      out_found_index_r <= kthie_pkg::FIDX_W'(res_idx);
      out_read_value_r  <= res_val;
      out_entry_total_r <= kthie_pkg::TOT_W'(count_nxt);
      out_evicted_r     <= res_evicted;
      out_dirty_r       <= dirty_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_index = out_found_index_r;
  assign out_read_value  = out_read_value_r;
  assign out_entry_total = out_entry_total_r;
  assign out_evicted     = out_evicted_r;
  assign out_dirty       = out_dirty_r;

endmodule

// ===== sv/keyed_table_head_insert_evict.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_table_head_insert_evict
// ordered key/value table with head insert, tail eviction and compaction
// ----------------------------------------------------------------------------
// usage:
//   in_chan carries one command item (add/replace, remove at position,
//   lookup by key, lookup by position); out_chan returns exactly one result
//   item per command, in order. both channels are valid/ready.
//   an item is taken when the block is idle; it passes through the
//   registered key compare (all entries at once) and then the table
//   update, which loads its result into the output register for out_chan.
//   the next item is taken only after the update step has finished with
//   the current one, once the block is back in idle.
//   the result sits in an output register; a new item is accepted while
//   it waits. if the receiver stalls, the item in flight holds in the
//   update step until the output register frees, and the block then
//   stops taking items.
//   reset empties the table (entry count zero) and clears the dirty flag;
//   stored entries are not cleared and no sweep is needed.
// ----------------------------------------------------------------------------
module keyed_table_head_insert_evict (
  input  logic        clk,
  input  logic        rst_n,
  kthie_in_if.sink    in_chan,
  kthie_out_if.source out_chan
);

  kthie_pkg::ctl_t ctl;
  kthie_pkg::sts_t sts;

  kthie_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  kthie_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .sts             (sts),
    .in_command      (in_chan.command),
    .in_key          (in_chan.key),
    .in_value        (in_chan.value),
    .in_position     (in_chan.position),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_status      (out_chan.status),
    .out_found_index (out_chan.found_index),
    .out_read_value  (out_chan.read_value),
    .out_entry_total (out_chan.entry_total),
    .out_evicted     (out_chan.evicted),
    .out_dirty       (out_chan.dirty)
  );

endmodule

// ===== sv/kthie_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kthie_checker
// port-level checks of the keyed head-insert table
// ----------------------------------------------------------------------------
module kthie_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_status,
  input logic [kthie_pkg::VAL_W-1:0]  out_read_value,
  input logic [kthie_pkg::TOT_W-1:0]  out_entry_total,
  input logic                         out_evicted,
  input logic                         out_dirty
);

  logic seen_dirty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_dirty_r <= 1'b0;
    end else if (out_valid && out_ready && out_dirty) begin
      seen_dirty_r <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_total <= kthie_pkg::TOT_W'(kthie_pkg::DEPTH))
    else $error("entry total above table depth");

  a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_read_value == '0 && !out_evicted)
    else $error("not-found item carries data or eviction");

  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> out_entry_total == kthie_pkg::TOT_W'(kthie_pkg::DEPTH))
    else $error("eviction reported on a table that is not full");

  a_dirty_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_dirty_r |-> out_dirty)
    else $error("dirty flag cleared after being set");

endmodule

bind keyed_table_head_insert_evict kthie_checker u_kthie_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_status      (out_chan.status),
  .out_read_value  (out_chan.read_value),
  .out_entry_total (out_chan.entry_total),
  .out_evicted     (out_chan.evicted),
  .out_dirty       (out_chan.dirty)
);

// ===== bench/tb_keyed_table_head_insert_evict.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_table_head_insert_evict
// drives directed and random command streams into the keyed head-insert
// table, keeps a behavioral copy of the table contents, and checks every
// result item in order while both channels idle and stall at random
// ----------------------------------------------------------------------------
module tb_keyed_table_head_insert_evict;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_GAP      = 17;
  localparam int SHOWN_ERRORS = 10;
  localparam int POOL_SIZE    = 16;
  localparam logic [kthie_pkg::KEY_W-1:0] FILL_KEY_BASE = 64'hF00D_0000_0000_0000;

  typedef struct packed {
    logic                         status;
    logic [kthie_pkg::FIDX_W-1:0] found_index;
    logic [kthie_pkg::VAL_W-1:0]  read_value;
    logic [kthie_pkg::TOT_W-1:0]  entry_total;
    logic                         evicted;
    logic                         dirty;
  } reply_t;

  logic clk;
  logic rst_n;

  kthie_in_if  in_if ();
  kthie_out_if out_if ();

  keyed_table_head_insert_evict DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  logic [kthie_pkg::KEY_W-1:0] tbl_keys [kthie_pkg::DEPTH];
  logic [kthie_pkg::VAL_W-1:0] tbl_vals [kthie_pkg::DEPTH];
  int                          tbl_count;
  logic                        tbl_dirty;
  logic [kthie_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
  reply_t                      pending_replies [$];

  int error_count;
  int cycle_count;
  bit no_gaps;
  bit in_valid_high;
  bit out_ready_high;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int draw_gap();
    if (no_gaps) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  // behavioral table: updates the copy and returns the reply of one command
  task automatic apply_command(input kthie_pkg::cmd_t cmd,
                               input logic [kthie_pkg::KEY_W-1:0] k,
                               input logic [kthie_pkg::VAL_W-1:0] v,
                               input logic [kthie_pkg::POS_W-1:0] p,
                               output reply_t r);
    int hit;
    int n;
    r = '0;
    hit = -1;
    for (int i = 0; i < tbl_count; i++)
      if (hit < 0 && tbl_keys[i] == k) hit = i;
    case (cmd)
      kthie_pkg::CMD_ADD: begin
        if (hit >= 0) begin
          tbl_vals[hit] = v;
          r.found_index = hit[kthie_pkg::FIDX_W-1:0];
        end else begin
          n = tbl_count;
          if (n >= kthie_pkg::DEPTH) begin
            n = kthie_pkg::DEPTH - 1;
            r.evicted = 1'b1;
          end
          for (int i = n; i > 0; i--) begin
            tbl_keys[i] = tbl_keys[i-1];
            tbl_vals[i] = tbl_vals[i-1];
          end
          tbl_keys[0] = k;
          tbl_vals[0] = v;
          tbl_count = n + 1;
        end
        tbl_dirty = 1'b1;
      end
      kthie_pkg::CMD_REMOVE: begin
        if (int'(p) < tbl_count) begin
          for (int i = int'(p); i + 1 < tbl_count; i++) begin
            tbl_keys[i] = tbl_keys[i+1];
            tbl_vals[i] = tbl_vals[i+1];
          end
          tbl_count--;
          tbl_dirty = 1'b1;
          r.found_index = p[kthie_pkg::FIDX_W-1:0];
        end else begin
          r.status = 1'b1;
        end
      end
      kthie_pkg::CMD_LOOKUP_KEY: begin
        if (hit >= 0) begin
          r.found_index = hit[kthie_pkg::FIDX_W-1:0];
          r.read_value  = tbl_vals[hit];
        end else begin
          r.status = 1'b1;
        end
      end
      default: begin
        if (int'(p) < tbl_count) begin
          r.found_index = p[kthie_pkg::FIDX_W-1:0];
          r.read_value  = tbl_vals[p[kthie_pkg::IDX_W-1:0]];
        end else begin
          r.status = 1'b1;
        end
      end
    endcase
    r.entry_total = tbl_count[kthie_pkg::TOT_W-1:0];
    r.dirty       = tbl_dirty;
  endtask

  task automatic send_item(input kthie_pkg::cmd_t cmd,
                           input logic [kthie_pkg::KEY_W-1:0] k,
                           input logic [kthie_pkg::VAL_W-1:0] v,
                           input logic [kthie_pkg::POS_W-1:0] p);
    int gap;
    reply_t r;
    gap = draw_gap();
    if (gap > 0) begin
      if (in_valid_high) begin
        in_if.valid <= 1'b0;
        in_valid_high = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    in_if.command  <= cmd;
    in_if.key      <= k;
    in_if.value    <= v;
    in_if.position <= p;
    if (!in_valid_high) begin
      in_if.valid <= 1'b1;
      in_valid_high = 1'b1;
    end
    do @(posedge clk); while (in_if.ready !== 1'b1);
    apply_command(cmd, k, v, p, r);
    pending_replies.push_back(r);
  endtask

  task automatic stop_input();
    if (in_valid_high) begin
      in_if.valid <= 1'b0;
      in_valid_high = 1'b0;
    end
  endtask

  task automatic wait_for_results();
    stop_input();
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  function automatic logic [kthie_pkg::KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45 && tbl_count > 0) return tbl_keys[$urandom_range(0, tbl_count - 1)];
    if (r < 70) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return {$urandom, $urandom};
  endfunction

  function automatic logic [kthie_pkg::VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '1;
    if (r == 1) return '0;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [kthie_pkg::POS_W-1:0] pick_position();
    if ($urandom_range(0, 9) < 7 && tbl_count > 0)
      return kthie_pkg::POS_W'($urandom_range(0, tbl_count - 1));
    return kthie_pkg::POS_W'($urandom_range(0, 63));
  endfunction

  task automatic test_empty_table();
    send_item(kthie_pkg::CMD_LOOKUP_KEY, '0, '0, '0);
    send_item(kthie_pkg::CMD_LOOKUP_POS, '1, '1, 6'd0);
    send_item(kthie_pkg::CMD_LOOKUP_POS, '0, '0, 6'd63);
    send_item(kthie_pkg::CMD_REMOVE, '0, '0, 6'd0);
    send_item(kthie_pkg::CMD_REMOVE, '1, '1, 6'd63);
  endtask

  task automatic test_add_replace_lookup();
    send_item(kthie_pkg::CMD_ADD, '0, '0, 6'd0);
    send_item(kthie_pkg::CMD_ADD, '1, '1, 6'd63);
    send_item(kthie_pkg::CMD_ADD, 64'h5, 64'hDEAD_BEEF_0123_4567, 6'd0);
    // replace with the same value still marks the table dirty
    send_item(kthie_pkg::CMD_ADD, 64'h5, 64'hDEAD_BEEF_0123_4567, 6'd0);
    send_item(kthie_pkg::CMD_ADD, '1, 64'h8000_0000_0000_0001, 6'd0);
    send_item(kthie_pkg::CMD_LOOKUP_KEY, '0, '1, 6'd0);
    send_item(kthie_pkg::CMD_LOOKUP_KEY, '1, '0, 6'd0);
    send_item(kthie_pkg::CMD_LOOKUP_KEY, 64'h6, '0, 6'd0);
    send_item(kthie_pkg::CMD_LOOKUP_POS, '0, '0, 6'd1);
    send_item(kthie_pkg::CMD_LOOKUP_POS, '0, '0, 6'd3);
    send_item(kthie_pkg::CMD_REMOVE, '0, '0, 6'd1);
    send_item(kthie_pkg::CMD_REMOVE, '0, '0, 6'd2);
    send_item(kthie_pkg::CMD_LOOKUP_POS, '0, '0, 6'd1);
    send_item(kthie_pkg::CMD_REMOVE, '0, '0, 6'd1);
    send_item(kthie_pkg::CMD_REMOVE, '0, '0, 6'd0);
    send_item(kthie_pkg::CMD_LOOKUP_KEY, 64'h5, '0, 6'd0);
  endtask

  task automatic test_fill_and_evict();
    // hold the sender until the table is quiet before filling it
    wait_for_results();
    for (int i = 0; i < kthie_pkg::DEPTH + 3; i++)
      send_item(kthie_pkg::CMD_ADD, FILL_KEY_BASE | kthie_pkg::KEY_W'(i),
                {$urandom, $urandom}, 6'd0);
    send_item(kthie_pkg::CMD_LOOKUP_KEY, FILL_KEY_BASE | 64'd2, '0, 6'd0);
    send_item(kthie_pkg::CMD_LOOKUP_KEY, FILL_KEY_BASE | 64'd3, '0, 6'd0);
    send_item(kthie_pkg::CMD_LOOKUP_POS, '0, '0, 6'd31);
    send_item(kthie_pkg::CMD_LOOKUP_POS, '0, '0, 6'd32);
    send_item(kthie_pkg::CMD_ADD, FILL_KEY_BASE | 64'd3, '1, 6'd0);
    send_item(kthie_pkg::CMD_REMOVE, '0, '0, 6'd32);
    send_item(kthie_pkg::CMD_REMOVE, '0, '0, 6'd31);
    send_item(kthie_pkg::CMD_REMOVE, '0, '0, 6'd0);
    send_item(kthie_pkg::CMD_ADD, '1, '0, 6'd0);
    send_item(kthie_pkg::CMD_ADD, '0, '1, 6'd0);
    send_item(kthie_pkg::CMD_LOOKUP_POS, '0, '0, 6'd31);
  endtask

  task automatic run_random_phase(input int items, input int add_pct,
                                  input int rem_pct, input int lkey_pct);
    int r;
    kthie_pkg::cmd_t cmd;
    for (int n = 0; n < items; n++) begin
      if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < add_pct) cmd = kthie_pkg::CMD_ADD;
      else if (r < add_pct + rem_pct) cmd = kthie_pkg::CMD_REMOVE;
      else if (r < add_pct + rem_pct + lkey_pct) cmd = kthie_pkg::CMD_LOOKUP_KEY;
      else cmd = kthie_pkg::CMD_LOOKUP_POS;
      send_item(cmd, pick_key(), pick_value(), pick_position());
    end
    no_gaps = 1'b0;
    wait_for_results();
  endtask

  task automatic test_random_mix();
    run_random_phase(250, 70, 10, 10);
    run_random_phase(250, 40, 30, 15);
    run_random_phase(250, 15, 60, 15);
    run_random_phase(250, 25, 15, 30);
  endtask

  // result side: random stalls, in-order compare against the oldest reply
  initial begin
    reply_t want;
    reply_t got;
    int stall;
    out_if.ready <= 1'b0;
    out_ready_high = 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        if (out_ready_high) begin
          out_if.ready <= 1'b0;
          out_ready_high = 1'b0;
        end
        repeat (stall) @(posedge clk);
      end
      if (!out_ready_high) begin
        out_if.ready <= 1'b1;
        out_ready_high = 1'b1;
      end
      do @(posedge clk); while (out_if.valid !== 1'b1);
      got.status      = out_if.status;
      got.found_index = out_if.found_index;
      got.read_value  = out_if.read_value;
      got.entry_total = out_if.entry_total;
      got.evicted     = out_if.evicted;
      got.dirty       = out_if.dirty;
      if (pending_replies.size() == 0) begin
        error_count++;
        if (error_count <= SHOWN_ERRORS)
          $display("unexpected result item at cycle %0d", cycle_count);
      end else begin
        want = pending_replies.pop_front();
        if (got !== want) begin
          error_count++;
          if (error_count <= SHOWN_ERRORS) begin
            $display("mismatch at cycle %0d", cycle_count);
            $display("  exp status=%0d idx=%0d value=%h total=%0d evicted=%0d dirty=%0d",
                     want.status, want.found_index, want.read_value, want.entry_total,
                     want.evicted, want.dirty);
            $display("  got status=%0d idx=%0d value=%h total=%0d evicted=%0d dirty=%0d",
                     got.status, got.found_index, got.read_value, got.entry_total,
                     got.evicted, got.dirty);
          end
        end
      end
    end
  end

  initial begin
    in_if.valid    <= 1'b0;
    in_if.command  <= kthie_pkg::CMD_ADD;
    in_if.key      <= '0;
    in_if.value    <= '0;
    in_if.position <= '0;
    rst_n          <= 1'b0;
    tbl_count = 0;
    tbl_dirty = 1'b0;
    for (int i = 0; i < kthie_pkg::DEPTH; i++) begin
      tbl_keys[i] = '0;
      tbl_vals[i] = '0;
    end
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_add_replace_lookup();
    test_fill_and_evict();
    test_random_mix();
    wait_for_results();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== keyed_table_head_insert_evict.f =====
sv/kthie_pkg.sv
sv/kthie_ifs.sv
sv/kthie_ctrl.sv
sv/kthie_dpath.sv
sv/keyed_table_head_insert_evict.sv
sv/kthie_checker.sv
bench/tb_keyed_table_head_insert_evict.sv
